>>> sv/csvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared constants and types of the csv line field splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

  localparam int FIELD_MAX_DEFAULT  = 512;
  localparam int MAX_FIELDS_DEFAULT = 16;

  localparam logic [4:0] EXPECTED_RESET = 5'd12;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_ACCEPT    = 2'd2;
  localparam logic [1:0] KIND_REJECT    = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNCLOSED = 3'd1;
  localparam logic [2:0] ERR_TOO_FEW  = 3'd2;
  localparam logic [2:0] ERR_TOO_MANY = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG = 3'd4;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [3:0] field_number;
    logic [7:0] data_byte;
    logic [2:0] error_code;
  } result_t;

endpackage

>>> sv/csvs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvs interfaces
// Valid/ready channels for line bytes, results and the configuration write.
// ----------------------------------------------------------------------------
interface csvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       line_end;

  modport source (output valid, output byte_value, output line_end, input ready);
  modport sink   (input valid, input byte_value, input line_end, output ready);
endinterface

interface csvs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] field_number;
  logic [7:0] data_byte;
  logic [2:0] error_code;

  modport source (output valid, output kind, output field_number, output data_byte,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input field_number, input data_byte,
                  input error_code, output ready);
endinterface

interface csvs_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/csvs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvs_step
// Per-byte parser update: next line state and the result of one transaction.
// ----------------------------------------------------------------------------
module csvs_step #(
  parameter int FIELD_MAX  = csvs_pkg::FIELD_MAX_DEFAULT,
  parameter int MAX_FIELDS = csvs_pkg::MAX_FIELDS_DEFAULT,
  parameter int LW         = $clog2(FIELD_MAX),
  parameter int FW         = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1
) (
  input  logic [7:0]        byte_value,
  input  logic              line_end,
  input  logic [4:0]        field_goal,
  input  logic              quoted_mode,
  input  logic              quote_pending,
  input  logic [FW-1:0]     current_field,
  input  logic [LW-1:0]     current_length,
  input  logic [2:0]        latched_error,
  output logic              quoted_mode_next,
  output logic              quote_pending_next,
  output logic [FW-1:0]     current_field_next,
  output logic [LW-1:0]     current_length_next,
  output logic [2:0]        latched_error_next,
  output csvs_pkg::result_t res
);
  import csvs_pkg::*;

  logic [6:0]  field_ext;
  logic [6:0]  field_p1;
  logic [LW:0] len_p1;
  logic        do_unq;
  logic        do_put;
  logic [7:0]  put_byte;
  logic [2:0]  end_err;

  assign field_ext = 7'(current_field);
  assign field_p1  = field_ext + 7'd1;
  assign len_p1    = (LW + 1)'(current_length) + (LW + 1)'(1);

  always_comb begin
    quoted_mode_next    = quoted_mode;
    quote_pending_next  = quote_pending;
    current_field_next  = current_field;
    current_length_next = current_length;
    latched_error_next  = latched_error;
    res.valid           = 1'b0;
    res.kind            = KIND_DATA;
    res.field_number    = field_ext[3:0];
    res.data_byte       = 8'd0;
    res.error_code      = ERR_NONE;
    do_unq              = 1'b0;
    do_put              = 1'b0;
    put_byte            = byte_value;
    end_err             = latched_error;

    if (line_end) begin
      if (latched_error == ERR_NONE) begin
        if (quoted_mode && !quote_pending) begin
          end_err = ERR_UNCLOSED;
        end else if (field_goal == 5'd0) begin
          end_err = ERR_TOO_MANY;
        end else if (field_p1 != 7'(field_goal)) begin
          end_err = ERR_TOO_FEW;
        end
      end
      res.valid           = 1'b1;
      res.kind            = (end_err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
      res.error_code      = end_err;
      quoted_mode_next    = 1'b0;
      quote_pending_next  = 1'b0;
      current_field_next  = '0;
      current_length_next = '0;
      latched_error_next  = ERR_NONE;
    end else if (latched_error == ERR_NONE) begin
      if (quoted_mode) begin
        if (quote_pending) begin
          quote_pending_next = 1'b0;
          if (byte_value == CH_QUOTE) begin
            do_put = 1'b1;
          end else begin
            // closing quote: the byte is taken as unquoted
            quoted_mode_next = 1'b0;
            do_unq           = 1'b1;
          end
        end else if (byte_value == CH_QUOTE) begin
          quote_pending_next = 1'b1;
        end else begin
          do_put = 1'b1;
        end
      end else begin
        do_unq = 1'b1;
      end

      if (do_unq) begin
        if (byte_value == CH_QUOTE) begin
          quoted_mode_next = 1'b1;
        end else if (byte_value == CH_COMMA) begin
          if (field_p1 >= 7'(field_goal) || field_p1 >= 7'(MAX_FIELDS)) begin
            latched_error_next = ERR_TOO_MANY;
          end else begin
            res.valid           = 1'b1;
            res.kind            = KIND_FIELD_END;
            current_field_next  = field_p1[FW-1:0];
            current_length_next = '0;
          end
        end else begin
          do_put = 1'b1;
        end
      end

      if (do_put) begin
        if (len_p1 >= (LW + 1)'(FIELD_MAX)) begin
          latched_error_next = ERR_TOO_LONG;
        end else begin
          current_length_next = len_p1[LW-1:0];
          res.valid           = 1'b1;
          res.kind            = KIND_DATA;
          res.data_byte       = put_byte;
        end
      end
    end
  end

endmodule

>>> sv/csv_line_field_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_line_field_splitter
// Splits a csv line, one byte per transaction, into data bytes and field ends.
// ----------------------------------------------------------------------------
// The block takes one byte (or a line end) per clock. Each accepted byte is
// parsed in the cycle it arrives and its result, if any, is loaded into a
// single output register, so a result appears in the cycle after its byte. The
// input is stalled only while that output register holds a result that the
// sink has not taken. Quotes open quoted mode, a doubled quote inside gives a
// literal quote, and an unquoted comma ends a field. The first error of a line
// is kept and the rest of the line gives no results; the line end returns
// accept or reject with the error code. The required field count is written
// through the cfg channel, which is always ready, and should be written
// between lines.
module csv_line_field_splitter #(
  parameter int FIELD_MAX  = csvs_pkg::FIELD_MAX_DEFAULT,
  parameter int MAX_FIELDS = csvs_pkg::MAX_FIELDS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  csvs_in_if.sink    items,
  csvs_out_if.source results,
  csvs_cfg_if.sink   cfg
);
  import csvs_pkg::*;

  localparam int LW = $clog2(FIELD_MAX);
  localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  logic [4:0]    field_goal;
  logic          quoted_mode;
  logic          quote_pending;
  logic [FW-1:0] current_field;
  logic [LW-1:0] current_length;
  logic [2:0]    latched_error;

  logic          quoted_mode_next;
  logic          quote_pending_next;
  logic [FW-1:0] current_field_next;
  logic [LW-1:0] current_length_next;
  logic [2:0]    latched_error_next;

  result_t       res;
  result_t       out_reg;
  logic          take;

  assign cfg.ready   = 1'b1;
  assign items.ready = !out_reg.valid || results.ready;
  assign take        = items.valid && items.ready;

  csvs_step #(
    .FIELD_MAX  (FIELD_MAX),
    .MAX_FIELDS (MAX_FIELDS),
    .LW         (LW),
    .FW         (FW)
  ) u_step (
    .byte_value          (items.byte_value),
    .line_end            (items.line_end),
    .field_goal          (field_goal),
    .quoted_mode         (quoted_mode),
    .quote_pending       (quote_pending),
    .current_field       (current_field),
    .current_length      (current_length),
    .latched_error       (latched_error),
    .quoted_mode_next    (quoted_mode_next),
    .quote_pending_next  (quote_pending_next),
    .current_field_next  (current_field_next),
    .current_length_next (current_length_next),
    .latched_error_next  (latched_error_next),
    .res                 (res)
  );

  // only the valid bit of the output register is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      field_goal     <= EXPECTED_RESET;
      quoted_mode    <= 1'b0;
      quote_pending  <= 1'b0;
      current_field  <= '0;
      current_length <= '0;
      latched_error  <= ERR_NONE;
      out_reg.valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        field_goal <= cfg.data;
      end
      if (take) begin
        quoted_mode    <= quoted_mode_next;
        quote_pending  <= quote_pending_next;
        current_field  <= current_field_next;
        current_length <= current_length_next;
        latched_error  <= latched_error_next;
        out_reg        <= res;
      end else if (results.ready) begin
        out_reg.valid <= 1'b0;
      end
    end
  end

  assign results.valid        = out_reg.valid;
  assign results.kind         = out_reg.kind;
  assign results.field_number = out_reg.field_number;
  assign results.data_byte    = out_reg.data_byte;
  assign results.error_code   = out_reg.error_code;

endmodule
